// ----- rtl/scvt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package scvt_pkg;

  localparam int ATOM_SLOTS = 4096;
  localparam int ADDR_W     = $clog2(ATOM_SLOTS);
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int WORD_W     = CNT_W + 3 * SUM_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic OP_TALLY = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_RD_A,
    S_WR_A,
    S_RD_B,
    S_WR_B,
    S_RD_Q,
    S_WR_Q
  } core_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_CMP,
    C_ROOTD,
    C_DIV,
    C_VN2,
    C_VN2C,
    C_ROOTV
  } calc_state_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [23:0]        ra;
    logic [23:0]        rb;
    logic [23:0]        skin;
  } calc_in_t;

  typedef struct packed {
    logic        done;
    logic        contact;
    logic [63:0] vn;
    logic [31:0] vt;
  } calc_out_t;

endpackage
`default_nettype wire

// ----- rtl/scvt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module scvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- rtl/scvt_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module scvt_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] operand,
  output logic             done,
  output logic [31:0]      root
);

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [63:0] trial;

  // one result bit per cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    trial    = r_r + bit_r;
    if (start) begin
      run_nxt = 1'b1;
      v_nxt   = operand;
      r_nxt   = '0;
      bit_nxt = 64'h4000_0000_0000_0000;
    end else if (run_r) begin
      if (v_r >= trial) begin
        v_nxt = v_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule
`default_nettype wire

// ----- rtl/scvt_calc.sv -----
`timescale 1ns / 1ps
`default_nettype none
module scvt_calc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire scvt_pkg::calc_in_t opnd,
  output scvt_pkg::calc_out_t     res
);

  scvt_pkg::calc_state_t state_r, state_nxt;

  scvt_pkg::calc_in_t op_r, op_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  ptag_r;
  logic        pvld_r, psgn_r;
  logic [63:0] prod_r;
  logic [63:0] rsq_r, rsq_nxt;
  logic [63:0] vsq_r, vsq_nxt;
  logic [63:0] pos_r, pos_nxt;
  logic [63:0] neg_r, neg_nxt;
  logic [63:0] rs2_r, rs2_nxt;
  logic [63:0] dot_r, dot_nxt;
  logic [31:0] dmag_r, dmag_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic [31:0] vt_r, vt_nxt;
  logic        contact_r, contact_nxt;
  logic        done_r, done_nxt;

  logic [31:0] mul_a, mul_b;
  logic        mul_sgn, mul_vld;
  logic [25:0] rs;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic        sq_start;
  logic [63:0] sq_opnd;
  logic        sq_done;
  logic [31:0] sq_root;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  assign rs = 26'(op_r.ra) + 26'(op_r.rb) + 26'(op_r.skin);

  // shared multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sgn = 1'b0;
    mul_vld = 1'b0;
    if (state_r == scvt_pkg::C_MUL) begin
      mul_vld = (cnt_r <= 4'd9);
      case (cnt_r)
        4'd0: begin mul_a = mag32(op_r.dx); mul_b = mul_a; end
        4'd1: begin mul_a = mag32(op_r.dy); mul_b = mul_a; end
        4'd2: begin mul_a = mag32(op_r.dz); mul_b = mul_a; end
        4'd3: begin mul_a = mag32(op_r.vx); mul_b = mul_a; end
        4'd4: begin mul_a = mag32(op_r.vy); mul_b = mul_a; end
        4'd5: begin mul_a = mag32(op_r.vz); mul_b = mul_a; end
        4'd6: begin
          mul_a = mag32(op_r.dx); mul_b = mag32(op_r.vx);
          mul_sgn = op_r.dx[31] ^ op_r.vx[31];
        end
        4'd7: begin
          mul_a = mag32(op_r.dy); mul_b = mag32(op_r.vy);
          mul_sgn = op_r.dy[31] ^ op_r.vy[31];
        end
        4'd8: begin
          mul_a = mag32(op_r.dz); mul_b = mag32(op_r.vz);
          mul_sgn = op_r.dz[31] ^ op_r.vz[31];
        end
        4'd9: begin mul_a = 32'(rs); mul_b = 32'(rs); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == scvt_pkg::C_VN2) begin
      mul_a = quo_r[31:0];
      mul_b = quo_r[31:0];
    end
  end

  assign rem_sh = {rem_r, quo_r[63]};
  assign div_ge = rem_sh >= {1'b0, dmag_r};

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    cnt_nxt     = cnt_r;
    rsq_nxt     = rsq_r;
    vsq_nxt     = vsq_r;
    pos_nxt     = pos_r;
    neg_nxt     = neg_r;
    rs2_nxt     = rs2_r;
    dot_nxt     = dot_r;
    dmag_nxt    = dmag_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dcnt_nxt    = dcnt_r;
    vt_nxt      = vt_r;
    contact_nxt = contact_r;
    done_nxt    = 1'b0;
    sq_start    = 1'b0;
    sq_opnd     = rsq_r;

    // accumulate the product issued in the previous cycle
    if (pvld_r) begin
      case (ptag_r)
        4'd0, 4'd1, 4'd2: rsq_nxt = rsq_r + prod_r;
        4'd3, 4'd4, 4'd5: vsq_nxt = vsq_r + prod_r;
        4'd6, 4'd7, 4'd8: begin
          if (psgn_r) neg_nxt = neg_r + prod_r;
          else        pos_nxt = pos_r + prod_r;
        end
        default: rs2_nxt = prod_r;
      endcase
    end

    case (state_r)
      scvt_pkg::C_IDLE: begin
        if (start) begin
          op_nxt    = opnd;
          cnt_nxt   = '0;
          rsq_nxt   = '0;
          vsq_nxt   = '0;
          pos_nxt   = '0;
          neg_nxt   = '0;
          state_nxt = scvt_pkg::C_MUL;
        end
      end
      scvt_pkg::C_MUL: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd10) state_nxt = scvt_pkg::C_CMP;
      end
      scvt_pkg::C_CMP: begin
        if (rsq_r > rs2_r) begin
          contact_nxt = 1'b0;
          quo_nxt     = '0;
          vt_nxt      = '0;
          done_nxt    = 1'b1;
          state_nxt   = scvt_pkg::C_IDLE;
        end else begin
          contact_nxt = 1'b1;
          dot_nxt     = (pos_r >= neg_r) ? pos_r - neg_r : neg_r - pos_r;
          sq_start    = 1'b1;
          sq_opnd     = rsq_r;
          state_nxt   = scvt_pkg::C_ROOTD;
        end
      end
      scvt_pkg::C_ROOTD: begin
        if (sq_done) begin
          dmag_nxt = sq_root;
          if (sq_root == '0) begin
            // coincident centres: no normal component
            quo_nxt   = '0;
            state_nxt = scvt_pkg::C_VN2;
          end else begin
            quo_nxt   = dot_r;
            rem_nxt   = '0;
            dcnt_nxt  = '0;
            state_nxt = scvt_pkg::C_DIV;
          end
        end
      end
      scvt_pkg::C_DIV: begin
        rem_nxt  = div_ge ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
        quo_nxt  = {quo_r[62:0], div_ge};
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd63) state_nxt = scvt_pkg::C_VN2;
      end
      scvt_pkg::C_VN2: begin
        if (quo_r[63:32] != '0) begin
          vt_nxt    = '0;
          done_nxt  = 1'b1;
          state_nxt = scvt_pkg::C_IDLE;
        end else begin
          state_nxt = scvt_pkg::C_VN2C;
        end
      end
      scvt_pkg::C_VN2C: begin
        if (prod_r >= vsq_r) begin
          vt_nxt    = '0;
          done_nxt  = 1'b1;
          state_nxt = scvt_pkg::C_IDLE;
        end else begin
          sq_start  = 1'b1;
          sq_opnd   = vsq_r - prod_r;
          state_nxt = scvt_pkg::C_ROOTV;
        end
      end
      scvt_pkg::C_ROOTV: begin
        if (sq_done) begin
          vt_nxt    = sq_root;
          done_nxt  = 1'b1;
          state_nxt = scvt_pkg::C_IDLE;
        end
      end
      default: state_nxt = scvt_pkg::C_IDLE;
    endcase
  end

  scvt_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_opnd),
    .done    (sq_done),
    .root    (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scvt_pkg::C_IDLE;
      done_r  <= 1'b0;
      pvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      pvld_r  <= mul_vld;
    end
    op_r      <= op_nxt;
    cnt_r     <= cnt_nxt;
    ptag_r    <= cnt_r;
    psgn_r    <= mul_sgn;
    prod_r    <= mul_a * mul_b;
    rsq_r     <= rsq_nxt;
    vsq_r     <= vsq_nxt;
    pos_r     <= pos_nxt;
    neg_r     <= neg_nxt;
    rs2_r     <= rs2_nxt;
    dot_r     <= dot_nxt;
    dmag_r    <= dmag_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dcnt_r    <= dcnt_nxt;
    vt_r      <= vt_nxt;
    contact_r <= contact_nxt;
  end

  assign res.done    = done_r;
  assign res.contact = contact_r;
  assign res.vn      = quo_r;
  assign res.vt      = vt_r;

endmodule
`default_nettype wire

// ----- rtl/sphere_contact_velocity_tally_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A read passes through states RD_Q and WR_Q before its result strobe; a tally that
// misses runs only the products and the compare, a contact at most a 32-step root, a
// 64-step divide, a second 32-step root, then two store read-modify-writes.
// Throughput: one item at a time, set by the iterative root/divide unit.
// Reset: synchronous; afterwards a clearing pass over all ATOM_SLOTS (4096) words keeps
// busy high. Results cannot be stalled by the receiver.
module sphere_contact_velocity_tally_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [11:0] in_atom_a,
  input  wire logic [11:0] in_atom_b,
  input  wire logic signed [31:0] in_delta_x,
  input  wire logic signed [31:0] in_delta_y,
  input  wire logic signed [31:0] in_delta_z,
  input  wire logic signed [31:0] in_rel_vel_x,
  input  wire logic signed [31:0] in_rel_vel_y,
  input  wire logic signed [31:0] in_rel_vel_z,
  input  wire logic [23:0] in_radius_a,
  input  wire logic [23:0] in_radius_b,
  output logic             out_valid,
  output logic             out_in_contact,
  output logic [31:0]      out_collision_count,
  output logic [47:0]      out_normal_speed_sum,
  output logic [47:0]      out_tangent_speed_sum,
  output logic [47:0]      out_partner_radius_sum
);

  localparam int AW = scvt_pkg::ADDR_W;
  localparam int CW = scvt_pkg::CNT_W;
  localparam int SW = scvt_pkg::SUM_W;
  localparam int WW = scvt_pkg::WORD_W;

  scvt_pkg::core_state_t state_r, state_nxt;

  logic [23:0]   skin_r;
  logic [11:0]   a_r, b_r;
  logic [23:0]   ra_r, rb_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          ov_r, ov_nxt;
  logic          oc_r, oc_nxt;
  logic [CW-1:0] ocnt_r, ocnt_nxt;
  logic [SW-1:0] onrm_r, onrm_nxt;
  logic [SW-1:0] otan_r, otan_nxt;
  logic [SW-1:0] orad_r, orad_nxt;

  logic          accept;
  logic          a_ok, b_ok;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [WW-1:0] ram_wdata, ram_rdata;
  logic [CW-1:0] rd_cnt;
  logic [SW-1:0] rd_nrm, rd_tan, rd_rad;
  logic [23:0]   add_rad;
  logic [WW-1:0] upd_word;

  scvt_pkg::calc_in_t  c_in;
  scvt_pkg::calc_out_t c_out;

  function automatic logic [SW-1:0] sat_sum(input logic [SW-1:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = 65'(a) + 65'(b);
    if (b >= 64'(scvt_pkg::SUM_MAX) || s > 65'(scvt_pkg::SUM_MAX)) sat_sum = scvt_pkg::SUM_MAX;
    else sat_sum = s[SW-1:0];
  endfunction

  assign busy   = (state_r != scvt_pkg::S_IDLE);
  assign accept = start && !busy;
  assign a_ok   = 32'(a_r) < 32'(scvt_pkg::ATOM_SLOTS);
  assign b_ok   = 32'(b_r) < 32'(scvt_pkg::ATOM_SLOTS);

  assign c_in.dx   = in_delta_x;
  assign c_in.dy   = in_delta_y;
  assign c_in.dz   = in_delta_z;
  assign c_in.vx   = in_rel_vel_x;
  assign c_in.vy   = in_rel_vel_y;
  assign c_in.vz   = in_rel_vel_z;
  assign c_in.ra   = in_radius_a;
  assign c_in.rb   = in_radius_b;
  assign c_in.skin = skin_r;

  scvt_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && in_opcode == scvt_pkg::OP_TALLY),
    .opnd  (c_in),
    .res   (c_out)
  );

  assign {rd_cnt, rd_nrm, rd_tan, rd_rad} = ram_rdata;
  assign add_rad = (state_r == scvt_pkg::S_WR_A) ? rb_r : ra_r;
  assign upd_word = {
    (rd_cnt == scvt_pkg::CNT_MAX) ? rd_cnt : rd_cnt + CW'(1),
    sat_sum(rd_nrm, c_out.vn),
    sat_sum(rd_tan, 64'(c_out.vt)),
    sat_sum(rd_rad, 64'(add_rad))
  };

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    ov_nxt    = 1'b0;
    oc_nxt    = oc_r;
    ocnt_nxt  = ocnt_r;
    onrm_nxt  = onrm_r;
    otan_nxt  = otan_r;
    orad_nxt  = orad_r;
    ram_we    = 1'b0;
    ram_addr  = AW'(a_r);
    ram_wdata = upd_word;

    case (state_r)
      scvt_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(scvt_pkg::ATOM_SLOTS - 1)) state_nxt = scvt_pkg::S_IDLE;
      end
      scvt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_opcode == scvt_pkg::OP_READ) state_nxt = scvt_pkg::S_RD_Q;
          else                                state_nxt = scvt_pkg::S_CALC;
        end
      end
      scvt_pkg::S_CALC: begin
        if (c_out.done) begin
          if (!c_out.contact) begin
            ov_nxt = 1'b1; oc_nxt = 1'b0;
            ocnt_nxt = '0; onrm_nxt = '0; otan_nxt = '0; orad_nxt = '0;
            state_nxt = scvt_pkg::S_IDLE;
          end else if (a_ok) begin
            state_nxt = scvt_pkg::S_RD_A;
          end else if (b_ok) begin
            state_nxt = scvt_pkg::S_RD_B;
          end else begin
            ov_nxt = 1'b1; oc_nxt = 1'b1;
            ocnt_nxt = '0; onrm_nxt = '0; otan_nxt = '0; orad_nxt = '0;
            state_nxt = scvt_pkg::S_IDLE;
          end
        end
      end
      scvt_pkg::S_RD_A: begin
        ram_addr  = AW'(a_r);
        state_nxt = scvt_pkg::S_WR_A;
      end
      scvt_pkg::S_WR_A: begin
        ram_addr = AW'(a_r);
        ram_we   = 1'b1;
        if (b_ok) begin
          state_nxt = scvt_pkg::S_RD_B;
        end else begin
          ov_nxt = 1'b1; oc_nxt = 1'b1;
          ocnt_nxt = '0; onrm_nxt = '0; otan_nxt = '0; orad_nxt = '0;
          state_nxt = scvt_pkg::S_IDLE;
        end
      end
      scvt_pkg::S_RD_B: begin
        // a same-atom pair sees the first update: it was written last cycle
        ram_addr  = AW'(b_r);
        state_nxt = scvt_pkg::S_WR_B;
      end
      scvt_pkg::S_WR_B: begin
        ram_addr = AW'(b_r);
        ram_we   = 1'b1;
        ov_nxt = 1'b1; oc_nxt = 1'b1;
        ocnt_nxt = '0; onrm_nxt = '0; otan_nxt = '0; orad_nxt = '0;
        state_nxt = scvt_pkg::S_IDLE;
      end
      scvt_pkg::S_RD_Q: begin
        ram_addr  = AW'(a_r);
        state_nxt = scvt_pkg::S_WR_Q;
      end
      scvt_pkg::S_WR_Q: begin
        ram_addr  = AW'(a_r);
        ram_we    = a_ok;
        ram_wdata = '0;
        ov_nxt    = 1'b1;
        oc_nxt    = 1'b0;
        ocnt_nxt  = a_ok ? rd_cnt : '0;
        onrm_nxt  = a_ok ? rd_nrm : '0;
        otan_nxt  = a_ok ? rd_tan : '0;
        orad_nxt  = a_ok ? rd_rad : '0;
        state_nxt = scvt_pkg::S_IDLE;
      end
      default: state_nxt = scvt_pkg::S_IDLE;
    endcase
  end

  scvt_ram #(
    .WIDTH (WW),
    .DEPTH (scvt_pkg::ATOM_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scvt_pkg::S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      skin_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) skin_r <= cfg_wdata;
    end
    if (accept) begin
      a_r  <= in_atom_a;
      b_r  <= in_atom_b;
      ra_r <= in_radius_a;
      rb_r <= in_radius_b;
    end
    oc_r   <= oc_nxt;
    ocnt_r <= ocnt_nxt;
    onrm_r <= onrm_nxt;
    otan_r <= otan_nxt;
    orad_r <= orad_nxt;
  end

  assign out_valid              = ov_r;
  assign out_in_contact         = oc_r;
  assign out_collision_count    = ocnt_r;
  assign out_normal_speed_sum   = onrm_r;
  assign out_tangent_speed_sum  = otan_r;
  assign out_partner_radius_sum = orad_r;

endmodule
`default_nettype wire

// ----- rtl/scvt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module scvt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_in_contact,
  input wire logic [31:0] out_collision_count,
  input wire logic [47:0] out_normal_speed_sum,
  input wire logic [47:0] out_tangent_speed_sum,
  input wire logic [47:0] out_partner_radius_sum
);

  // reset always starts the clearing pass
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in flight");

  a_tally_zero_sums: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_contact |-> out_collision_count == '0 &&
      out_normal_speed_sum == '0 && out_tangent_speed_sum == '0 &&
      out_partner_radius_sum == '0)
    else $error("tally result carries sums");

endmodule

bind sphere_contact_velocity_tally_core scvt_checker u_scvt_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .start                  (start),
  .busy                   (busy),
  .out_valid              (out_valid),
  .out_in_contact         (out_in_contact),
  .out_collision_count    (out_collision_count),
  .out_normal_speed_sum   (out_normal_speed_sum),
  .out_tangent_speed_sum  (out_tangent_speed_sum),
  .out_partner_radius_sum (out_partner_radius_sum)
);
`default_nettype wire

// ----- sim/sphere_contact_velocity_tally_core_tb.sv -----
`timescale 1ns / 1ps
module sphere_contact_velocity_tally_core_tb;

  typedef struct {
    logic        op;
    logic [11:0] a;
    logic [11:0] b;
    logic signed [31:0] dx, dy, dz;
    logic signed [31:0] vx, vy, vz;
    logic [23:0] ra;
    logic [23:0] rb;
  } pair_beat_t;

  typedef struct {
    logic        contact;
    logic [31:0] cnt;
    logic [47:0] nsum;
    logic [47:0] tsum;
    logic [47:0] rsum;
  } tally_res_t;

  typedef struct {
    pair_beat_t beat;
    bit         typed;
    tally_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = 1'b0;
  logic [11:0] in_atom_a = '0, in_atom_b = '0;
  logic signed [31:0] in_delta_x = '0, in_delta_y = '0, in_delta_z = '0;
  logic signed [31:0] in_rel_vel_x = '0, in_rel_vel_y = '0, in_rel_vel_z = '0;
  logic [23:0] in_radius_a = '0, in_radius_b = '0;
  logic out_valid, out_in_contact;
  logic [31:0] out_collision_count;
  logic [47:0] out_normal_speed_sum, out_tangent_speed_sum, out_partner_radius_sum;

  sphere_contact_velocity_tally_core u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_opcode(in_opcode),
    .in_atom_a(in_atom_a), .in_atom_b(in_atom_b),
    .in_delta_x(in_delta_x), .in_delta_y(in_delta_y), .in_delta_z(in_delta_z),
    .in_rel_vel_x(in_rel_vel_x), .in_rel_vel_y(in_rel_vel_y),
    .in_rel_vel_z(in_rel_vel_z),
    .in_radius_a(in_radius_a), .in_radius_b(in_radius_b),
    .out_valid(out_valid), .out_in_contact(out_in_contact),
    .out_collision_count(out_collision_count),
    .out_normal_speed_sum(out_normal_speed_sum),
    .out_tangent_speed_sum(out_tangent_speed_sum),
    .out_partner_radius_sum(out_partner_radius_sum)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow copy of the tally store and skin register
  logic [23:0] skin_shadow = '0;
  logic [31:0] count_shadow [scvt_pkg::ATOM_SLOTS];
  logic [47:0] normal_shadow [scvt_pkg::ATOM_SLOTS];
  logic [47:0] tangent_shadow [scvt_pkg::ATOM_SLOTS];
  logic [47:0] radius_shadow [scvt_pkg::ATOM_SLOTS];

  tally_res_t expected_q[$];
  int errors = 0;
  bit typed_pending = 1'b0;
  tally_res_t typed_res;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned add_clip(longint unsigned acc, longint unsigned x,
                                               longint unsigned lim);
    if (x >= lim || acc > lim - x) return lim;
    return acc + x;
  endfunction

  function automatic void tally_slot(logic [11:0] idx, longint unsigned vn,
                                     longint unsigned vt, longint unsigned rad);
    count_shadow[idx]   = add_clip(count_shadow[idx], 1, scvt_pkg::CNT_MAX);
    normal_shadow[idx]  = add_clip(normal_shadow[idx], vn, scvt_pkg::SUM_MAX);
    tangent_shadow[idx] = add_clip(tangent_shadow[idx], vt, scvt_pkg::SUM_MAX);
    radius_shadow[idx]  = add_clip(radius_shadow[idx], rad, scvt_pkg::SUM_MAX);
  endfunction

  // applies one beat to the shadow store and returns what the block should emit
  function automatic tally_res_t apply_pair(pair_beat_t p);
    tally_res_t r;
    longint d[3], v[3], prod;
    longint unsigned dsq, vsq, pos, neg, dot, dmag, vn, vt, rs;
    r = '{default: '0};
    if (p.op == scvt_pkg::OP_READ) begin
      r.cnt  = count_shadow[p.a];
      r.nsum = normal_shadow[p.a];
      r.tsum = tangent_shadow[p.a];
      r.rsum = radius_shadow[p.a];
      count_shadow[p.a] = '0;
      normal_shadow[p.a] = '0;
      tangent_shadow[p.a] = '0;
      radius_shadow[p.a] = '0;
      return r;
    end
    d[0] = p.dx; d[1] = p.dy; d[2] = p.dz;
    v[0] = p.vx; v[1] = p.vy; v[2] = p.vz;
    dsq = 0; vsq = 0; pos = 0; neg = 0;
    for (int k = 0; k < 3; k++) begin
      dsq += longint'(d[k] * d[k]);
      vsq += longint'(v[k] * v[k]);
      prod = d[k] * v[k];
      if (prod >= 0) pos += prod;
      else neg += -prod;
    end
    rs = longint'(p.ra) + longint'(p.rb) + longint'(skin_shadow);
    if (dsq > rs * rs) return r;
    r.contact = 1'b1;
    dot = (pos >= neg) ? pos - neg : neg - pos;
    dmag = floor_root(dsq);
    vn = (dmag == 0) ? 0 : dot / dmag;
    if (vn >= (64'd1 << 32) || vn * vn >= vsq) vt = 0;
    else vt = floor_root(vsq - vn * vn);
    tally_slot(p.a, vn, vt, p.rb);
    tally_slot(p.b, vn, vt, p.ra);
    return r;
  endfunction

  // accept / result monitor; results pop before a same-edge accept pushes
  always @(posedge clk) begin
    tally_res_t e, pr;
    pair_beat_t p;
    if (rst_n && cfg_we) skin_shadow <= cfg_wdata;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat contact=%0b cnt=%0d", $time,
                 out_in_contact, out_collision_count);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_in_contact !== e.contact) begin
          $display("%0t: in_contact exp %0b got %0b", $time, e.contact, out_in_contact);
          errors++;
        end
        if (out_collision_count !== e.cnt) begin
          $display("%0t: collision_count exp %0d got %0d", $time, e.cnt,
                   out_collision_count);
          errors++;
        end
        if (out_normal_speed_sum !== e.nsum) begin
          $display("%0t: normal_speed_sum exp %h got %h", $time, e.nsum,
                   out_normal_speed_sum);
          errors++;
        end
        if (out_tangent_speed_sum !== e.tsum) begin
          $display("%0t: tangent_speed_sum exp %h got %h", $time, e.tsum,
                   out_tangent_speed_sum);
          errors++;
        end
        if (out_partner_radius_sum !== e.rsum) begin
          $display("%0t: partner_radius_sum exp %h got %h", $time, e.rsum,
                   out_partner_radius_sum);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      p.op = in_opcode; p.a = in_atom_a; p.b = in_atom_b;
      p.dx = in_delta_x; p.dy = in_delta_y; p.dz = in_delta_z;
      p.vx = in_rel_vel_x; p.vy = in_rel_vel_y; p.vz = in_rel_vel_z;
      p.ra = in_radius_a; p.rb = in_radius_b;
      pr = apply_pair(p);
      expected_q.push_back(typed_pending ? typed_res : pr);
    end
  end

  task automatic send_pair(pair_beat_t p, bit typed, tally_res_t tr);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode = p.op; in_atom_a = p.a; in_atom_b = p.b;
    in_delta_x = p.dx; in_delta_y = p.dy; in_delta_z = p.dz;
    in_rel_vel_x = p.vx; in_rel_vel_y = p.vy; in_rel_vel_z = p.vz;
    in_radius_a = p.ra; in_radius_b = p.rb;
    typed_pending = typed;
    typed_res = tr;
    start = 1'b1;
    do @(posedge clk); while (!(start && !busy));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_skin(logic [23:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic pair_beat_t mk(logic op, logic [11:0] a, logic [11:0] b,
                                    int dx, int dy, int dz, int vx, int vy, int vz,
                                    logic [23:0] ra, logic [23:0] rb);
    pair_beat_t p;
    p.op = op; p.a = a; p.b = b;
    p.dx = dx; p.dy = dy; p.dz = dz;
    p.vx = vx; p.vy = vy; p.vz = vz;
    p.ra = ra; p.rb = rb;
    return p;
  endfunction

  function automatic pair_beat_t mk_read(logic [11:0] a);
    return mk(scvt_pkg::OP_READ, a, 0, 0, 0, 0, 0, 0, 0, 0, 0);
  endfunction

  function automatic int near_delta();
    return int'($urandom_range(0, 32'h60000)) - 32'sh30000;
  endfunction

  function automatic pair_beat_t rand_pair();
    pair_beat_t p;
    int sel;
    sel = $urandom_range(0, 99);
    p = mk(scvt_pkg::OP_TALLY, $urandom_range(0, 15), $urandom_range(0, 15),
           near_delta(), near_delta(), near_delta(),
           $urandom, $urandom, $urandom,
           $urandom_range(0, 24'h30000), $urandom_range(0, 24'h30000));
    if (sel < 8) p.vx = $urandom_range(0, 24'h3FFFF) - 24'h1FFFF;
    if (sel >= 65 && sel < 85) p.op = scvt_pkg::OP_READ;
    if (sel >= 85) begin
      // full-range noise, mostly misses
      p = mk($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return p;
  endfunction

  dir_row_t dir_tab[$];
  tally_res_t zero_res = '{default: '0};
  tally_res_t hit_res  = '{contact: 1'b1, default: '0};

  initial begin
    tally_res_t r;
    for (int i = 0; i < scvt_pkg::ATOM_SLOTS; i++) begin
      count_shadow[i] = '0; normal_shadow[i] = '0;
      tangent_shadow[i] = '0; radius_shadow[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // store is clear after reset
    dir_tab.push_back('{mk_read(0), 1, zero_res});
    dir_tab.push_back('{mk_read(4095), 1, zero_res});
    // far apart: miss
    dir_tab.push_back('{mk(scvt_pkg::OP_TALLY, 1, 2,
                           32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           0, 0, 0, 24'hFFFFFF, 24'hFFFFFF), 1, zero_res});
    // coincident centres: vn = 0, vt = |dv|
    dir_tab.push_back('{mk(scvt_pkg::OP_TALLY, 5, 6, 0, 0, 0, 32'h10000, 0, 0,
                           24'h10000, 24'h20000), 1, hit_res});
    r = '{1'b0, 32'd1, 48'd0, 48'h10000, 48'h20000};
    dir_tab.push_back('{mk_read(5), 1, r});
    r.rsum = 48'h10000;
    dir_tab.push_back('{mk_read(6), 1, r});
    // read clears
    dir_tab.push_back('{mk_read(5), 1, zero_res});
    // same atom on both sides gets two updates
    dir_tab.push_back('{mk(scvt_pkg::OP_TALLY, 7, 7, 0, 0, 0, 0, 0, 0,
                           24'h100, 24'h200), 1, hit_res});
    r = '{1'b0, 32'd2, 48'd0, 48'd0, 48'h300};
    dir_tab.push_back('{mk_read(7), 1, r});
    // extremes, predicted
    dir_tab.push_back('{mk(scvt_pkg::OP_TALLY, 4095, 4095,
                           32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000, 32'h80000000, 32'h80000000,
                           24'hFFFFFF, 24'hFFFFFF), 0, zero_res});
    dir_tab.push_back('{mk(scvt_pkg::OP_TALLY, 8, 9, 1, 0, 0,
                           32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                           24'hFFFFFF, 24'hFFFFFF), 0, zero_res});
    dir_tab.push_back('{mk(scvt_pkg::OP_TALLY, 8, 9, -32'sh8000, 32'sh4000, -32'sh2000,
                           32'sh30000, -32'sh10000, 32'sh7FFF, 24'h8000, 24'h4000),
                        0, zero_res});
    dir_tab.push_back('{mk(scvt_pkg::OP_TALLY, 9, 8, 32'sh10000, 0, 0, 32'sh10000, 0, 0,
                           24'h8000, 24'h8000), 0, zero_res});
    dir_tab.push_back('{mk_read(8), 0, zero_res});
    dir_tab.push_back('{mk_read(9), 0, zero_res});
    dir_tab.push_back('{mk_read(4095), 0, zero_res});

    write_skin(24'h0);
    foreach (dir_tab[i]) send_pair(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].res);

    // skin at top, random, and back to zero across phases
    write_skin(24'hFFFFFF);
    repeat (130) send_pair(rand_pair(), 0, zero_res);
    write_skin($urandom_range(0, 24'h40000));
    repeat (140) send_pair(rand_pair(), 0, zero_res);
    write_skin($urandom);
    repeat (140) send_pair(rand_pair(), 0, zero_res);
    write_skin(24'h0);
    repeat (140) send_pair(rand_pair(), 0, zero_res);
    // flush slots 0 to 15
    for (int i = 0; i < 16; i++) send_pair(mk_read(i), 0, zero_res);

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("sphere_contact_velocity_tally_core verification clean");
    else $display("sphere_contact_velocity_tally_core verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("sphere_contact_velocity_tally_core verification failed");
    $finish;
  end

endmodule
